// ===== src/u8d_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_pkg
// Types and constants shared by the UTF-8 decoder modules.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int unsigned CP_W  = 21;
    localparam int unsigned BYTE_W = 8;

    localparam logic [CP_W-1:0] REPL_CHAR   = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_SCALAR  = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_LEN2    = 21'h000080;
    localparam logic [CP_W-1:0] MIN_LEN3    = 21'h000800;
    localparam logic [CP_W-1:0] MIN_LEN4    = 21'h010000;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_text;
    } in_beat_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            last_of_run;
    } out_beat_t;

    typedef struct packed {
        logic [1:0]      pend_cnt;
        logic [2:0]      exp_len;
        logic [CP_W-1:0] partial;
    } u8d_state_t;

    typedef struct packed {
        logic            emit;
        logic [1:0]      repl_cnt;
        logic            has_final;
        logic [CP_W-1:0] final_cp;
    } u8d_run_t;

    function automatic logic [CP_W-1:0] check_value(input logic [CP_W-1:0] v,
                                                    input logic [2:0] len);
        logic bad;
        begin
            bad = 1'b0;
            if (len == LEN_TWO && v < MIN_LEN2)
            begin
                bad = 1'b1;
            end
            if (len == LEN_THREE && v < MIN_LEN3)
            begin
                bad = 1'b1;
            end
            if (len == LEN_FOUR && v < MIN_LEN4)
            begin
                bad = 1'b1;
            end
            if (v > MAX_SCALAR)
            begin
                bad = 1'b1;
            end
            if (v >= SURR_LO && v <= SURR_HI)
            begin
                bad = 1'b1;
            end
            check_value = bad ? REPL_CHAR : v;
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/u8d_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_step
// Decodes one byte against the held sequence state and describes the run of
// code points that the byte causes.
// ----------------------------------------------------------------------------
module u8d_step
    import u8d_pkg::*;
(
    input  wire in_beat_t   beat,
    input  wire u8d_state_t state,
    output u8d_state_t      state_next,
    output u8d_run_t        run
);

    logic [BYTE_W-1:0] b;
    logic              eot;
    logic [2:0]        lead_len;
    logic [CP_W-1:0]   lead_bits;
    logic              lead_final;
    logic [CP_W-1:0]   lead_cp;
    logic              lead_open;
    logic [2:0]        count;
    logic [CP_W-1:0]   v;

    assign b   = beat.text_byte;
    assign eot = beat.end_of_text;

    always_comb
    begin
        lead_len  = LEN_NONE;
        lead_bits = '0;
        if (b[7:5] == 3'b110)
        begin
            lead_len  = LEN_TWO;
            lead_bits = {16'd0, b[4:0]};
        end
        else if (b[7:4] == 4'b1110)
        begin
            lead_len  = LEN_THREE;
            lead_bits = {17'd0, b[3:0]};
        end
        else if (b[7:3] == 5'b11110)
        begin
            lead_len  = LEN_FOUR;
            lead_bits = {18'd0, b[2:0]};
        end

        lead_final = 1'b1;
        lead_open  = 1'b0;
        lead_cp    = REPL_CHAR;
        if (!b[7])
        begin
            lead_cp = {13'd0, b};
        end
        else if (lead_len != LEN_NONE && !eot)
        begin
            lead_final = 1'b0;
            lead_open  = 1'b1;
        end
    end

    assign count = {1'b0, state.pend_cnt} + 3'd1;
    assign v     = {state.partial[CP_W-7:0], b[5:0]};

    always_comb
    begin
        state_next = state;
        run        = '0;
        if (state.pend_cnt == 2'd0)
        begin
            run.has_final = lead_final;
            run.final_cp  = lead_cp;
            if (lead_open)
            begin
                state_next.pend_cnt = 2'd1;
                state_next.exp_len  = lead_len;
                state_next.partial  = lead_bits;
            end
        end
        else if (b[7:6] == 2'b10)
        begin
            if (count >= state.exp_len)
            begin
                run.has_final = 1'b1;
                run.final_cp  = check_value(v, state.exp_len);
                state_next    = '0;
            end
            else if (eot)
            begin
                run.repl_cnt = count[1:0];
                state_next   = '0;
            end
            else
            begin
                state_next.pend_cnt = count[1:0];
                state_next.partial  = v;
            end
        end
        else
        begin
            run.repl_cnt  = state.pend_cnt;
            run.has_final = lead_final;
            run.final_cp  = lead_cp;
            state_next    = '0;
            if (lead_open)
            begin
                state_next.pend_cnt = 2'd1;
                state_next.exp_len  = lead_len;
                state_next.partial  = lead_bits;
            end
        end
        if (eot)
        begin
            state_next = '0;
        end
        run.emit = run.has_final || (run.repl_cnt != 2'd0);
    end

endmodule
`default_nettype wire

// ===== src/utf8_to_codepoint_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder
// UTF-8 byte stream to Unicode code points with U+FFFD replacement.
// The first code point of a byte is valid in the cycle after the byte is taken.
// One byte per cycle while the output register is empty or sends its last
// code point; a byte that yields N (0 to 4) code points holds it until taken.
// Reset: rst_n clears the held sequence and empties the output register at once.
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder
    import u8d_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     byte_valid,
    output logic          byte_ready,
    input  wire in_beat_t byte_data,
    output logic          cp_valid,
    input  wire logic     cp_ready,
    output out_beat_t     cp_data
);

    u8d_state_t      state_reg;
    u8d_state_t      state_next;
    u8d_run_t        run;
    logic            run_valid_reg;
    logic            run_valid_next;
    logic [1:0]      run_repl_reg;
    logic [1:0]      run_repl_next;
    logic            run_final_reg;
    logic            run_final_next;
    logic [CP_W-1:0] run_cp_reg;
    logic [CP_W-1:0] run_cp_next;
    logic            cp_last;
    logic            cp_fire;
    logic            byte_fire;

    u8d_step u_step
    (
        .beat       (byte_data),
        .state      (state_reg),
        .state_next (state_next),
        .run        (run)
    );

    assign cp_last    = (run_repl_reg == 2'd0) || (run_repl_reg == 2'd1 && !run_final_reg);
    assign cp_valid   = run_valid_reg;
    assign cp_fire    = cp_valid && cp_ready;
    assign byte_ready = !run_valid_reg || (cp_ready && cp_last);
    assign byte_fire  = byte_valid && byte_ready;

    assign cp_data.code_point  = (run_repl_reg != 2'd0) ? REPL_CHAR : run_cp_reg;
    assign cp_data.last_of_run = cp_last;

    always_comb
    begin
        run_valid_next = run_valid_reg;
        run_repl_next  = run_repl_reg;
        run_final_next = run_final_reg;
        run_cp_next    = run_cp_reg;
        if (cp_fire)
        begin
            if (cp_last)
            begin
                run_valid_next = 1'b0;
            end
            else
            begin
                run_repl_next = run_repl_reg - 2'd1;
            end
        end
        if (byte_fire && run.emit)
        begin
            run_valid_next = 1'b1;
            run_repl_next  = run.repl_cnt;
            run_final_next = run.has_final;
            run_cp_next    = run.final_cp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            run_valid_reg <= 1'b0;
            run_repl_reg  <= 2'd0;
            run_final_reg <= 1'b0;
        end
        else
        begin
            if (byte_fire)
            begin
                state_reg <= state_next;
            end
            run_valid_reg <= run_valid_next;
            run_repl_reg  <= run_repl_next;
            run_final_reg <= run_final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_cp_reg <= run_cp_next;
    end

    // A run that is shown always holds at least one code point.
    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid |-> (run_repl_reg != 2'd0 || run_final_reg))
        else $error("empty run in output register");

    a_cp_range: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid |-> (cp_data.code_point <= MAX_SCALAR))
        else $error("code point above U+10FFFF");

    a_eot_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_fire && byte_data.end_of_text) |=> (state_reg.pend_cnt == 2'd0))
        else $error("sequence still open after end of text");

    a_open_seq_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.pend_cnt != 2'd0) |->
            (state_reg.exp_len >= LEN_TWO && state_reg.exp_len <= LEN_FOUR &&
             {1'b0, state_reg.pend_cnt} < state_reg.exp_len))
        else $error("held sequence count out of range");

endmodule
`default_nettype wire

// ===== dv/utf8_to_codepoint_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder_tb
// Self-checking bench for the UTF-8 to code point decoder. Bytes go in over a
// valid/ready channel, with random gaps in the last two tests. An in-bench
// decoder predicts every code point and run marker, and each output beat is
// checked against it in order. Directed patterns come first, then random text
// behind a long output stall, then well-formed text, then malformed sequences.
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder_tb
    import u8d_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int TAIL_CYCLES    = 10;
    localparam int MAX_REPORTS    = 40;

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_ready;
    in_beat_t  byte_data;
    logic      cp_valid;
    logic      cp_ready = 1'b0;
    out_beat_t cp_data;

    // Decoder state mirrored by the bench.
    logic [1:0]      seq_held;
    logic [2:0]      seq_len;
    logic [CP_W-1:0] seq_bits;

    logic [CP_W-1:0] byte_cps [$];
    out_beat_t       cp_expected [$];
    out_beat_t       want;

    logic tx_idle_en  = 1'b0;
    logic rx_idle_en  = 1'b0;
    logic holdoff_req = 1'b0;
    int   holdoff_left = 0;
    int   rx_stall_left = 0;
    int   stuck_cycles = 0;
    int   error_count = 0;
    int   tx_sent = 0;
    int   bytes_in = 0;
    int   texts_ended = 0;
    int   cps_out = 0;
    int   repl_out = 0;

    utf8_to_codepoint_decoder i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .cp_valid   (cp_valid),
        .cp_ready   (cp_ready),
        .cp_data    (cp_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [CP_W-1:0] screen_value(input logic [CP_W-1:0] v,
                                                     input logic [2:0] len);
        logic [CP_W-1:0] min_val;
        case (len)
            LEN_TWO:   min_val = MIN_LEN2;
            LEN_THREE: min_val = MIN_LEN3;
            default:   min_val = MIN_LEN4;
        endcase
        if (v < min_val || v > MAX_SCALAR || (v >= SURR_LO && v <= SURR_HI))
        begin
            return REPL_CHAR;
        end
        return v;
    endfunction

    task automatic queue_cp(input logic [CP_W-1:0] cp);
        byte_cps = {byte_cps, cp};
    endtask

    task automatic drop_sequence();
        seq_held = 2'd0;
        seq_len  = LEN_NONE;
        seq_bits = '0;
    endtask

    task automatic open_lead(input logic [7:0] b, input logic eot);
        logic [2:0]      len;
        logic [CP_W-1:0] bits;
        len  = LEN_NONE;
        bits = '0;
        if (!b[7])
        begin
            queue_cp({{(CP_W-8){1'b0}}, b});
        end
        else
        begin
            if (b[7:5] == 3'b110)
            begin
                len  = LEN_TWO;
                bits = {16'd0, b[4:0]};
            end
            else if (b[7:4] == 4'b1110)
            begin
                len  = LEN_THREE;
                bits = {17'd0, b[3:0]};
            end
            else if (b[7:3] == 5'b11110)
            begin
                len  = LEN_FOUR;
                bits = {18'd0, b[2:0]};
            end
            if (len == LEN_NONE || eot)
            begin
                queue_cp(REPL_CHAR);
            end
            else
            begin
                seq_held = 2'd1;
                seq_len  = len;
                seq_bits = bits;
            end
        end
    endtask

    task automatic predict_code_points(input in_beat_t beat);
        logic [2:0]      held_now;
        logic [CP_W-1:0] grown;
        out_beat_t       item;
        byte_cps.delete();
        if (seq_held == 2'd0)
        begin
            open_lead(beat.text_byte, beat.end_of_text);
        end
        else if (beat.text_byte[7:6] == 2'b10)
        begin
            held_now = {1'b0, seq_held} + 3'd1;
            grown    = {seq_bits[CP_W-7:0], beat.text_byte[5:0]};
            if (held_now >= seq_len)
            begin
                queue_cp(screen_value(grown, seq_len));
                drop_sequence();
            end
            else if (beat.end_of_text)
            begin
                repeat (held_now) queue_cp(REPL_CHAR);
                drop_sequence();
            end
            else
            begin
                seq_held = held_now[1:0];
                seq_bits = grown;
            end
        end
        else
        begin
            repeat (seq_held) queue_cp(REPL_CHAR);
            drop_sequence();
            open_lead(beat.text_byte, beat.end_of_text);
        end
        if (beat.end_of_text)
        begin
            drop_sequence();
        end
        foreach (byte_cps[i])
        begin
            item.code_point  = byte_cps[i];
            item.last_of_run = (i == byte_cps.size() - 1);
            cp_expected = {cp_expected, item};
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("MISMATCH at %0t ns: %s, got 0x%0h, expected 0x%0h",
                     $time, what, got, exp_val);
        end
    endtask

    // Input beats feed the predictor; output beats are checked in order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
            begin
                predict_code_points(byte_data);
                bytes_in++;
                if (byte_data.end_of_text)
                begin
                    texts_ended++;
                end
            end
            if (cp_valid && cp_ready)
            begin
                cps_out++;
                if (cp_data.code_point == REPL_CHAR)
                begin
                    repl_out++;
                end
                if (cp_expected.size() == 0)
                begin
                    report_mismatch("code point with none expected",
                                    32'(cp_data.code_point), 32'd0);
                end
                else
                begin
                    want = cp_expected.pop_front();
                    if (cp_data.code_point !== want.code_point)
                    begin
                        report_mismatch("code_point", 32'(cp_data.code_point),
                                        32'(want.code_point));
                    end
                    if (cp_data.last_of_run !== want.last_of_run)
                    begin
                        report_mismatch("last_of_run", 32'(cp_data.last_of_run),
                                        32'(want.last_of_run));
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (holdoff_req)
        begin
            holdoff_req  = 1'b0;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left != 0)
        begin
            holdoff_left = holdoff_left - 1;
            cp_ready = 1'b0;
        end
        else if (rx_stall_left != 0)
        begin
            rx_stall_left = rx_stall_left - 1;
            cp_ready = 1'b0;
        end
        else
        begin
            rx_stall_left = rx_idle_en ? idle_gap() : 0;
            cp_ready = (rx_stall_left == 0);
            if (rx_stall_left != 0)
            begin
                rx_stall_left = rx_stall_left - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((byte_valid && byte_ready) || (cp_valid && cp_ready))
        begin
            stuck_cycles = 0;
        end
        else
        begin
            stuck_cycles = stuck_cycles + 1;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no beat for %0d cycles, %0d code points outstanding",
                     stuck_cycles, cp_expected.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = tx_idle_en ? idle_gap() : 0;
        if (gap != 0)
        begin
            @(negedge clk);
            byte_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        byte_valid            = 1'b1;
        byte_data.text_byte   = b;
        byte_data.end_of_text = eot;
        tx_sent++;
        do
        begin
            @(posedge clk);
        end
        while (!byte_ready);
    endtask

    task automatic send_char(input logic [CP_W-1:0] cp, input logic eot);
        if (cp < MIN_LEN2)
        begin
            send_byte(cp[7:0], eot);
        end
        else if (cp < MIN_LEN3)
        begin
            send_byte({3'b110, cp[10:6]}, 1'b0);
            send_byte({2'b10, cp[5:0]}, eot);
        end
        else if (cp < MIN_LEN4)
        begin
            send_byte({4'b1110, cp[15:12]}, 1'b0);
            send_byte({2'b10, cp[11:6]}, 1'b0);
            send_byte({2'b10, cp[5:0]}, eot);
        end
        else
        begin
            send_byte({5'b11110, cp[20:18]}, 1'b0);
            send_byte({2'b10, cp[17:12]}, 1'b0);
            send_byte({2'b10, cp[11:6]}, 1'b0);
            send_byte({2'b10, cp[5:0]}, eot);
        end
    endtask

    function automatic logic [CP_W-1:0] random_scalar();
        logic [CP_W-1:0] cp;
        case ($urandom_range(0, 3))
            0:       cp = CP_W'($urandom_range(0, 'h7F));
            1:       cp = CP_W'($urandom_range('h80, 'h7FF));
            2:       cp = CP_W'($urandom_range('h800, 'hFFFF));
            default: cp = CP_W'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        byte_valid = 1'b0;
        while (cp_expected.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_directed_cases();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hDF, 1'b0); send_byte(8'hBF, 1'b0);
        send_byte(8'hE0, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
        // Overlong, surrogate and above the scalar range.
        send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hF4, 1'b0); send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Three held bytes broken by an ASCII byte give four code points.
        send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0); send_byte(8'h41, 1'b0);
        send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1);
        send_byte(8'hC2, 1'b1);
        wait_drained();
    endtask

    task automatic test_output_holdoff();
        int target;
        tx_idle_en  = 1'b0;
        rx_idle_en  = 1'b0;
        target      = tx_sent + 24;
        holdoff_req = 1'b1;
        while (tx_sent < target)
        begin
            send_char(random_scalar(), 1'b0);
        end
        wait_drained();
    endtask

    task automatic test_wellformed_text();
        int target;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        target     = tx_sent + 75;
        while (tx_sent < target)
        begin
            send_char(random_scalar(), $urandom_range(0, 11) == 0);
        end
        wait_drained();
    endtask

    task automatic test_broken_sequences();
        int         target;
        int         kind;
        int         len;
        int         conts;
        logic [7:0] lead;
        logic [7:0] b;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        target     = tx_sent + 50;
        while (tx_sent < target)
        begin
            kind = $urandom_range(0, 3);
            if (kind == 0)
            begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
            else
            begin
                len = $urandom_range(2, 4);
                case (len)
                    2:       lead = {3'b110, 5'($urandom_range(0, 31))};
                    3:       lead = {4'b1110, 4'($urandom_range(0, 15))};
                    default: lead = {5'b11110, 3'($urandom_range(0, 7))};
                endcase
                conts = (kind == 1) ? len - 1 : $urandom_range(0, len - 2);
                send_byte(lead, kind == 3 && conts == 0);
                for (int k = 0; k < conts; k++)
                begin
                    send_byte({2'b10, 6'($urandom_range(0, 63))},
                              kind == 3 && k == conts - 1);
                end
                if (kind == 2)
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b[7:6] == 2'b10)
                    begin
                        b[6] = 1'b1;
                    end
                    send_byte(b, $urandom_range(0, 5) == 0);
                end
            end
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        byte_data  = '0;
        drop_sequence();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_output_holdoff();
        test_wellformed_text();
        test_broken_sequences();

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Decoded %0d bytes over %0d text ends into %0d code points.",
                 bytes_in, texts_ended, cps_out);
        $display("%0d replacement characters, %0d mismatches.", repl_out, error_count);
        if (error_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
